[sv/iirq_pkg.sv]
// Shared types, codes and sizes for the indexed insert/remove queue
`timescale 1ns / 1ps
`default_nettype none

package iirq_pkg;

  // number of cells in the row
  localparam int DEPTH = 16;
  // width of a count or a position, able to hold DEPTH itself
  localparam int CNT_W = 5;
  localparam int DATA_W = 32;

  // request op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    logic      tap_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/iirq_cell.sv]
// One storage cell of the queue row: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module iirq_cell (
  input  wire                                     clk,
  input  wire iirq_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [iirq_pkg::DATA_W-1:0] new_value,
  input  wire logic signed [iirq_pkg::DATA_W-1:0] left_value,
  input  wire logic signed [iirq_pkg::DATA_W-1:0] right_value,
  output logic signed [iirq_pkg::DATA_W-1:0]      data,
  output logic signed [iirq_pkg::DATA_W-1:0]      tap
);
  import iirq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // pick the next entry for this cell
  always_comb begin
    unique case (ctrl.act)
      CELL_LOAD:       data_nxt = new_value;
      CELL_FROM_LEFT:  data_nxt = left_value;
      CELL_FROM_RIGHT: data_nxt = right_value;
      default:         data_nxt = data_r;
    endcase
  end

  // entry storage, no reset: only filled cells are ever read
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // gated copy for the or-tree that reads the removed entry
  assign tap  = ctrl.tap_en ? data_r : '0;

endmodule

`default_nettype wire

[sv/indexed_insert_remove_queue.sv]
// Top level: ordered store of signed words with insert and remove at an index
// The result strobe is registered and comes in the cycle after an accepted request.
// Throughput: one request per cycle; busy stays low, since every cell of the
// row shifts in parallel and the result register cannot be stalled.
// Reset: clears the fill count and the result strobe; cell contents are left
// as they are and count as empty. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module indexed_insert_remove_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire iirq_pkg::req_t in_req,
  output logic                out_valid,
  output iirq_pkg::rsp_t      out_rsp
);
  import iirq_pkg::*;

  logic                     accept;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  rsp_t                     out_rsp_r;
  rsp_t                     rsp_nxt;
  logic                     ins_ok;
  logic                     rem_ok;
  logic [CNT_W-1:0]         eff_pos;
  logic [CNT_W-1:0]         last_idx;
  logic signed [DATA_W-1:0] removed;
  cell_ctrl_t               ctrl   [DEPTH];
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] taps   [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // clamp the position to the tail and qualify the operation
  always_comb begin
    last_idx = count_r - CNT_W'(1);
    ins_ok   = accept && (in_req.op == OP_INSERT) && (count_r < CNT_W'(DEPTH));
    rem_ok   = accept && (in_req.op == OP_REMOVE) && (count_r != '0);
    if (in_req.op == OP_INSERT) begin
      eff_pos = (in_req.position > count_r) ? count_r : in_req.position;
    end else begin
      eff_pos = (in_req.position >= count_r) ? last_idx : in_req.position;
    end
  end

  // per-cell shift controls
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].act    = CELL_HOLD;
      ctrl[i].tap_en = rem_ok && (CNT_W'(i) == eff_pos);
      if (ins_ok) begin
        if (CNT_W'(i) == eff_pos) begin
          ctrl[i].act = CELL_LOAD;
        end else if (CNT_W'(i) > eff_pos) begin
          ctrl[i].act = CELL_FROM_LEFT;
        end
      end else if (rem_ok && (CNT_W'(i) >= eff_pos)) begin
        ctrl[i].act = CELL_FROM_RIGHT;
      end
    end
  end

  // row of cells, each linked to its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (g == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end
    iirq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[g]),
      .new_value   (in_req.value),
      .left_value  (left_v),
      .right_value (right_v),
      .data        (cell_q[g]),
      .tap         (taps[g])
    );
  end

  // or-reduce the gated taps to get the removed entry
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | taps[i];
    end
  end

  // next count and result
  always_comb begin
    count_nxt = count_r;
    rsp_nxt.status        = ST_OK;
    rsp_nxt.removed_value = '0;
    case (in_req.op)
      OP_INSERT: begin
        if (ins_ok) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          rsp_nxt.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (rem_ok) begin
          count_nxt = last_idx;
          rsp_nxt.removed_value = removed;
        end else begin
          rsp_nxt.status = ST_EMPTY;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
    rsp_nxt.count = count_nxt;
  end

  // count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // fill count never passes the row length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // every accepted request gives exactly one strobe on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("request without result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid_r)
    else $error("result without request");

  // full and empty reports agree with the reported count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == ST_FULL) |-> out_rsp_r.count == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == ST_EMPTY) |-> out_rsp_r.count == '0)
    else $error("empty status with entries left");

endmodule

`default_nettype wire

[sim/iirq_checker.sv]
// Checker for the indexed insert/remove queue: tracks requests, predicts results, compares
`timescale 1ns / 1ps

module iirq_checker
  import iirq_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire               busy,
  input  req_t              in_req,
  input  wire               out_valid,
  input  rsp_t              out_rsp,
  output int unsigned       mismatches,
  output int unsigned       rsps_outstanding
);

  // shadow copy of the stored row, head first
  logic signed [DATA_W-1:0] row_shadow [DEPTH];
  int                       fill_shadow = 0;

  // results predicted but not yet seen on the result port
  rsp_t pending_rsps [$];

  // apply one request to the shadow row and return the result it should give
  function automatic rsp_t apply_to_store(req_t r);
    rsp_t res;
    int   pos;
    res.status = ST_OK;
    res.removed_value = '0;
    pos = int'(r.position);
    case (r.op)
      OP_INSERT: begin
        if (fill_shadow >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (pos > fill_shadow) pos = fill_shadow;
          for (int i = fill_shadow; i > pos; i--) row_shadow[i] = row_shadow[i-1];
          row_shadow[pos] = r.value;
          fill_shadow++;
        end
      end
      OP_REMOVE: begin
        if (fill_shadow == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (pos >= fill_shadow) pos = fill_shadow - 1;
          res.removed_value = row_shadow[pos];
          for (int i = pos; i + 1 < fill_shadow; i++) row_shadow[i] = row_shadow[i+1];
          fill_shadow--;
        end
      end
      OP_CLEAR: begin
        fill_shadow = 0;
      end
      default: begin
        // unused op code leaves everything as it is
      end
    endcase
    res.count = fill_shadow[CNT_W-1:0];
    return res;
  endfunction

  // compare each result strobe with the oldest prediction, then log new requests
  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_rsps.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d removed %0d count %0d",
                   $time, out_rsp.status, out_rsp.removed_value, out_rsp.count);
          errs++;
        end else begin
          want = pending_rsps.pop_front();
          if (out_rsp.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_rsp.status);
            errs++;
          end
          if (out_rsp.removed_value !== want.removed_value) begin
            $display("%0t: removed_value mismatch: expected %0d actual %0d",
                     $time, want.removed_value, out_rsp.removed_value);
            errs++;
          end
          if (out_rsp.count !== want.count) begin
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count, out_rsp.count);
            errs++;
          end
        end
      end
      if (start && !busy) pending_rsps.push_back(apply_to_store(in_req));
    end
    mismatches <= mismatches + errs;
    rsps_outstanding <= pending_rsps.size();
  end

endmodule

[sim/tb_indexed_insert_remove_queue.sv]
// Testbench top for the indexed insert/remove queue: clock, reset, requests, verdict
`timescale 1ns / 1ps

module tb_indexed_insert_remove_queue;
  import iirq_pkg::*;

  // op code with no function in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 2000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        in_req;
  logic        out_valid;
  rsp_t        out_rsp;
  int unsigned mismatches;
  int unsigned rsps_outstanding;
  int          idle_pct;

  indexed_insert_remove_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  iirq_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req           (in_req),
    .out_valid        (out_valid),
    .out_rsp          (out_rsp),
    .mismatches       (mismatches),
    .rsps_outstanding (rsps_outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic req_t mk_req(logic [1:0] op, logic signed [DATA_W-1:0] value,
                                  logic [CNT_W-1:0] position);
    req_t r;
    r.op = op;
    r.value = value;
    r.position = position;
    return r;
  endfunction

  // issue one request, with random idle cycles ahead of it
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_req <= mk_req(2'($urandom_range(0, 3)), $urandom(), 5'($urandom_range(0, 31)));
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (rsps_outstanding != 0) @(posedge clk);
  endtask

  // random request; tilt steers toward filling, draining or a mix
  function automatic req_t random_req(int tilt);
    int          pick;
    int          ins_pct;
    logic [1:0]  op;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0] pos;
    ins_pct = (tilt == 0) ? 75 : (tilt == 1) ? 20 : 45;
    pick = $urandom_range(0, 99);
    if (pick < 3)                op = OP_CLEAR;
    else if (pick < 6)           op = OP_UNUSED;
    else if (pick < 6 + ins_pct) op = OP_INSERT;
    else                         op = OP_REMOVE;
    case ($urandom_range(0, 19))
      0:       value = 32'sh7FFF_FFFF;
      1:       value = 32'sh8000_0000;
      2:       value = '0;
      3:       value = '1;
      default: value = $urandom();
    endcase
    if ($urandom_range(0, 9) < 7) pos = 5'($urandom_range(0, DEPTH));
    else                          pos = 5'($urandom_range(0, 31));
    return mk_req(op, value, pos);
  endfunction

  // stimulus and verdict
  initial begin
    int tilt;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    idle_pct = 13;
    tilt = 2;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store corners
    send_request(mk_req(OP_REMOVE, 32'sd5, 5'd0));
    send_request(mk_req(OP_UNUSED, 32'sd9, 5'd3));
    send_request(mk_req(OP_CLEAR, 32'sd0, 5'd0));
    // directed: inserts at tail, head and middle, with extreme values
    send_request(mk_req(OP_INSERT, 32'sh7FFF_FFFF, 5'd31));
    send_request(mk_req(OP_INSERT, 32'sh8000_0000, 5'd0));
    send_request(mk_req(OP_INSERT, 32'sd0, 5'd1));
    for (int i = 3; i < DEPTH; i++)
      send_request(mk_req(OP_INSERT, $urandom(), 5'($urandom_range(0, i + 1))));
    // directed: insert on full store, then removes at tail, head, middle
    send_request(mk_req(OP_INSERT, -32'sd1, 5'd4));
    send_request(mk_req(OP_REMOVE, 32'sd0, 5'd31));
    send_request(mk_req(OP_REMOVE, 32'sd0, 5'd0));
    send_request(mk_req(OP_REMOVE, 32'sh5555_AAAA, 5'd5));
    send_request(mk_req(OP_UNUSED, 32'sd0, 5'd16));
    send_request(mk_req(OP_CLEAR, 32'sd0, 5'd7));
    drain_results();

    // random requests in three idling phases
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        drain_results();
        idle_pct = 70;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        drain_results();
        idle_pct = 0;
      end
      if (n % 48 == 0) tilt = $urandom_range(0, 2);
      send_request(random_req(tilt));
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
sv/iirq_pkg.sv
sv/iirq_cell.sv
sv/indexed_insert_remove_queue.sv
sim/iirq_checker.sv
sim/tb_indexed_insert_remove_queue.sv
